@@ sv/ppm_level_peak_hold_meter_assert.svh @@
// Assertion macros for the meter. Each check is sampled on the rising
// edge of clk and switched off while rst_n is low.
`ifndef PPM_LEVEL_PEAK_HOLD_METER_ASSERT_SVH
`define PPM_LEVEL_PEAK_HOLD_METER_ASSERT_SVH
`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent
`define PPM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ppm meter: same-cycle check failed");
// Consequent must hold in the cycle after the antecedent
`define PPM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ppm meter: next-cycle check failed");
`else
`define PPM_ASSERT_NOW(label, ante, cons)
`define PPM_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ sv/ppm_pkg.sv @@
`default_nettype none

package ppm_pkg;

    // Item operation codes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // Register map (index = byte address / 4)
    localparam int unsigned APB_ADDR_W = 4;
    localparam logic [1:0] REG_RELEASE   = 2'd0;
    localparam logic [1:0] REG_PEAK_FALL = 2'd1;
    localparam logic [1:0] REG_FLOOR     = 2'd2;
    localparam logic [1:0] REG_HOLD      = 2'd3;

    // Register reset values
    localparam logic [15:0] RELEASE_RST   = 16'd55476;
    localparam logic [15:0] PEAK_FALL_RST = 16'd64972;
    localparam logic [14:0] FLOOR_RST     = 15'd13;
    localparam logic [7:0]  HOLD_RST      = 8'd40;

    // Field widths
    localparam int unsigned SAMPLE_W    = 16;
    localparam int unsigned FACTOR_W    = 16;
    localparam int unsigned FLOOR_W     = 15;
    localparam int unsigned LEVEL_OUT_W = 15;
    localparam int unsigned SEG_OUT_W   = 7;

    // Division by 100 of a quotient below 2^15: (q * DIV_RECIP) >> DIV_SHIFT
    // is exact over the whole range.
    localparam int unsigned QUOT_W    = 15;
    localparam int unsigned DIV_SHIFT = 22;
    localparam logic [15:0] DIV_RECIP = 16'd41944;
    localparam int unsigned SEG_RAW_W = 9;

    typedef struct packed {
        logic                op;
        logic [SAMPLE_W-1:0] sample_level;
    } in_item_t;

    typedef struct packed {
        logic [LEVEL_OUT_W-1:0] level_out;
        logic [LEVEL_OUT_W-1:0] peak_out;
        logic [SEG_OUT_W-1:0]   lit_segments;
        logic [SEG_OUT_W-1:0]   peak_segment;
        logic                   peak_visible;
    } out_item_t;

    typedef struct packed {
        logic [FACTOR_W-1:0] release_factor;
        logic [FACTOR_W-1:0] peak_fall_factor;
        logic [FLOOR_W-1:0]  floor_level;
        logic [7:0]          hold_ticks;
    } cfg_t;

endpackage

`default_nettype wire

@@ sv/ppm_cfg_regs.sv @@
`default_nettype none

module ppm_cfg_regs
    import ppm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    // Register writes on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.release_factor   <= RELEASE_RST;
            cfg_reg.peak_fall_factor <= PEAK_FALL_RST;
            cfg_reg.floor_level      <= FLOOR_RST;
            cfg_reg.hold_ticks       <= HOLD_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_RELEASE:   cfg_reg.release_factor   <= pwdata[FACTOR_W-1:0];
                REG_PEAK_FALL: cfg_reg.peak_fall_factor <= pwdata[FACTOR_W-1:0];
                REG_FLOOR:     cfg_reg.floor_level      <= pwdata[FLOOR_W-1:0];
                REG_HOLD:      cfg_reg.hold_ticks       <= pwdata[7:0];
                default:       ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        case (reg_idx)
            REG_RELEASE:   prdata = 32'(cfg_reg.release_factor);
            REG_PEAK_FALL: prdata = 32'(cfg_reg.peak_fall_factor);
            REG_FLOOR:     prdata = 32'(cfg_reg.floor_level);
            REG_HOLD:      prdata = 32'(cfg_reg.hold_ticks);
            default:       prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

@@ sv/ppm_ballistics.sv @@
`default_nettype none

module ppm_ballistics
    import ppm_pkg::*;
#(
    parameter int unsigned FRACTION_BITS = 8,
    localparam int unsigned FULL_SCALE = 100 << FRACTION_BITS,
    localparam int unsigned LEVEL_MAX  = (FULL_SCALE < 65535) ? FULL_SCALE : 65535,
    localparam int unsigned LW         = $clog2(LEVEL_MAX + 1)
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire cfg_t          cfg,
    input  wire logic          item_valid,
    output logic               item_ready,
    input  wire in_item_t      item,
    output logic               level_valid,
    input  wire logic          level_ready,
    output logic      [LW-1:0] level,
    output logic      [LW-1:0] peak
);

    localparam int unsigned CW = (LW > FLOOR_W) ? LW : FLOOR_W;

    logic [LW-1:0] pending_level_reg;
    logic          sample_pending_reg;
    logic [LW-1:0] tracked_level_reg;
    logic [LW-1:0] held_peak_reg;
    logic [7:0]    hold_counter_reg;
    logic          level_valid_reg;

    logic [LW-1:0] tracked_level_next;
    logic [LW-1:0] held_peak_next;
    logic [7:0]    hold_counter_next;

    logic          accept;
    logic          tick;
    logic [LW-1:0] sample_clamped;
    logic [LW+15:0] lvl_prod;
    logic [LW+15:0] pk_prod;
    logic [LW-1:0] lvl_decay;
    logic [LW-1:0] pk_decay;
    logic [LW-1:0] lvl_pre;
    logic [7:0]    hold_inc;

    // State registers hold the tick result until the next stage takes it
    assign item_ready  = !level_valid_reg || level_ready;
    assign accept      = item_valid && item_ready;
    assign tick        = accept && (item.op == OP_TICK);
    assign level_valid = level_valid_reg;
    assign level       = tracked_level_reg;
    assign peak        = held_peak_reg;

    // Sample clamped to full scale
    assign sample_clamped = (32'(item.sample_level) > 32'(FULL_SCALE)) ?
                            LW'(FULL_SCALE) : LW'(item.sample_level);

    // Q0.16 decays, truncated
    assign lvl_prod  = (LW+16)'(tracked_level_reg) * (LW+16)'(cfg.release_factor);
    assign pk_prod   = (LW+16)'(held_peak_reg) * (LW+16)'(cfg.peak_fall_factor);
    assign lvl_decay = lvl_prod[LW+15:16];
    assign pk_decay  = pk_prod[LW+15:16];
    assign hold_inc  = (hold_counter_reg == 8'hFF) ? hold_counter_reg
                                                    : hold_counter_reg + 8'd1;

    // Level and peak ballistics for one tick
    always_comb
    begin
        if (sample_pending_reg)
        begin
            if (pending_level_reg >= tracked_level_reg)
                lvl_pre = pending_level_reg;
            else
                lvl_pre = (lvl_decay > pending_level_reg) ? lvl_decay : pending_level_reg;
        end
        else
        begin
            lvl_pre = lvl_decay;
        end

        if (CW'(lvl_pre) < CW'(cfg.floor_level))
            tracked_level_next = '0;
        else
            tracked_level_next = lvl_pre;

        held_peak_next    = held_peak_reg;
        hold_counter_next = hold_counter_reg;
        if (tracked_level_next > held_peak_reg)
        begin
            held_peak_next    = tracked_level_next;
            hold_counter_next = '0;
        end
        else if (held_peak_reg != '0)
        begin
            hold_counter_next = hold_inc;
            if (hold_inc > cfg.hold_ticks)
            begin
                if (CW'(pk_decay) < CW'(cfg.floor_level))
                    held_peak_next = '0;
                else
                    held_peak_next = pk_decay;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_level_reg  <= '0;
            sample_pending_reg <= 1'b0;
            tracked_level_reg  <= '0;
            held_peak_reg      <= '0;
            hold_counter_reg   <= '0;
            level_valid_reg    <= 1'b0;
        end
        else
        begin
            if (accept && (item.op == OP_SAMPLE))
            begin
                pending_level_reg  <= sample_clamped;
                sample_pending_reg <= 1'b1;
            end
            else if (tick)
            begin
                sample_pending_reg <= 1'b0;
                tracked_level_reg  <= tracked_level_next;
                held_peak_reg      <= held_peak_next;
                hold_counter_reg   <= hold_counter_next;
            end

            if (tick)
                level_valid_reg <= 1'b1;
            else if (level_ready)
                level_valid_reg <= 1'b0;
        end
    end

endmodule

`default_nettype wire

@@ sv/ppm_seg_scale.sv @@
`default_nettype none

module ppm_seg_scale
    import ppm_pkg::*;
#(
    parameter int unsigned SEGMENTS      = 120,
    parameter int unsigned FRACTION_BITS = 8,
    localparam int unsigned FULL_SCALE = 100 << FRACTION_BITS,
    localparam int unsigned LEVEL_MAX  = (FULL_SCALE < 65535) ? FULL_SCALE : 65535,
    localparam int unsigned LW         = $clog2(LEVEL_MAX + 1)
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          level_valid,
    output logic               level_ready,
    input  wire logic [LW-1:0] level,
    input  wire logic [LW-1:0] peak,
    output logic               result_valid,
    input  wire logic          result_ready,
    output out_item_t          result
);

    // Numerators of the two divisions by full scale (lit rounds up, peak rounds to nearest)
    localparam int unsigned LIT_MAX = LEVEL_MAX * SEGMENTS + FULL_SCALE - 1;
    localparam int unsigned PKS_MAX = LEVEL_MAX * 2 * (SEGMENTS - 1) + FULL_SCALE;
    localparam int unsigned PLW     = $clog2(LIT_MAX + 1);
    localparam int unsigned PPW     = $clog2(PKS_MAX + 1);
    localparam int unsigned MW      = QUOT_W + 16;

    logic [PLW-1:0] lit_num_reg;
    logic [PPW-1:0] pks_num_reg;
    logic [LW-1:0]  level_reg;
    logic [LW-1:0]  peak_reg;
    logic           vis_reg;
    logic           s2_valid_reg;
    out_item_t      result_reg;
    logic           result_valid_reg;

    logic [PLW-1:0] lit_num_next;
    logic [PPW-1:0] pks_num_next;
    out_item_t      result_next;
    logic           s2_adv;
    logic [QUOT_W-1:0]    lit_quot;
    logic [QUOT_W-1:0]    pks_quot;
    logic [MW-1:0]        lit_prod;
    logic [MW-1:0]        pks_prod;
    logic [SEG_RAW_W-1:0] lit_raw;
    logic [SEG_RAW_W-1:0] pks_raw;
    logic [7:0]           lit_sat;
    logic [7:0]           pks_sat;

    assign s2_adv       = s2_valid_reg && (!result_valid_reg || result_ready);
    assign level_ready  = !s2_valid_reg || s2_adv;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Stage 2: constant multiplies, rounding offsets folded in
    assign lit_num_next = PLW'(PLW'(level) * PLW'(SEGMENTS) + PLW'(FULL_SCALE - 1));
    assign pks_num_next = PPW'(PPW'(peak) * PPW'(2 * (SEGMENTS - 1)) + PPW'(FULL_SCALE));

    always_ff @(posedge clk)
    begin
        if (level_valid && level_ready)
        begin
            lit_num_reg <= lit_num_next;
            pks_num_reg <= pks_num_next;
            level_reg   <= level;
            peak_reg    <= peak;
            vis_reg     <= (peak > level);
        end
    end

    // Stage 3: divide by 100 << FRACTION_BITS (peak by twice that) as shift then reciprocal multiply
    assign lit_quot = QUOT_W'(lit_num_reg >> FRACTION_BITS);
    assign pks_quot = QUOT_W'(pks_num_reg >> (FRACTION_BITS + 1));
    assign lit_prod = MW'(lit_quot) * MW'(DIV_RECIP);
    assign pks_prod = MW'(pks_quot) * MW'(DIV_RECIP);
    assign lit_raw  = lit_prod[DIV_SHIFT+SEG_RAW_W-1:DIV_SHIFT];
    assign pks_raw  = pks_prod[DIV_SHIFT+SEG_RAW_W-1:DIV_SHIFT];
    assign lit_sat  = (lit_raw > SEG_RAW_W'(SEGMENTS)) ? 8'(SEGMENTS) : 8'(lit_raw);
    assign pks_sat  = (pks_raw > SEG_RAW_W'(SEGMENTS - 1)) ? 8'(SEGMENTS - 1) : 8'(pks_raw);

    always_comb
    begin
        result_next.level_out    = LEVEL_OUT_W'(level_reg);
        result_next.peak_out     = LEVEL_OUT_W'(peak_reg);
        result_next.lit_segments = SEG_OUT_W'(lit_sat);
        result_next.peak_segment = vis_reg ? SEG_OUT_W'(pks_sat) : '0;
        result_next.peak_visible = vis_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv)
            result_reg <= result_next;
    end

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (level_valid && level_ready)
                s2_valid_reg <= 1'b1;
            else if (s2_adv)
                s2_valid_reg <= 1'b0;

            if (s2_adv)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;
        end
    end

endmodule

`default_nettype wire

@@ sv/ppm_level_peak_hold_meter.sv @@
// Peak programme meter level tracker with peak hold. Sample items latch a
// pending level and give no result; each tick item updates level and peak
// and gives one result with the bar segment counts. One item is accepted
// every clock cycle while item_ready is high; a tick's result is registered
// through the state register, a segment-product register and the result
// register. The level/peak state update (two 16-bit factor multiplies and
// their compares) sits between the input port and the state registers and
// sets the cycle time. The user is to write registers over the APB port
// only while no item is in flight; the block itself does not enforce it.
`default_nettype none

`include "ppm_level_peak_hold_meter_assert.svh"

module ppm_level_peak_hold_meter
    import ppm_pkg::*;
#(
    parameter int unsigned SEGMENTS      = 120,
    parameter int unsigned FRACTION_BITS = 8
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready,
    input  wire logic                  item_valid,
    output logic                       item_ready,
    input  wire in_item_t              item,
    output logic                       result_valid,
    input  wire logic                  result_ready,
    output out_item_t                  result
);

    localparam int unsigned FULL_SCALE = 100 << FRACTION_BITS;
    localparam int unsigned LEVEL_MAX  = (FULL_SCALE < 65535) ? FULL_SCALE : 65535;
    localparam int unsigned LW         = $clog2(LEVEL_MAX + 1);

    cfg_t          cfg;
    logic          bl_valid;
    logic          bl_ready;
    logic [LW-1:0] bl_level;
    logic [LW-1:0] bl_peak;

    ppm_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ppm_ballistics #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_ballistics (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .level_valid (bl_valid),
        .level_ready (bl_ready),
        .level       (bl_level),
        .peak        (bl_peak)
    );

    ppm_seg_scale #(
        .SEGMENTS      (SEGMENTS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_seg (
        .clk          (clk),
        .rst_n        (rst_n),
        .level_valid  (bl_valid),
        .level_ready  (bl_ready),
        .level        (bl_level),
        .peak         (bl_peak),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // Hidden peak marker reads as segment zero
    `PPM_ASSERT_NOW(a_hidden_peak_seg, result_valid && !result.peak_visible, result.peak_segment == '0)
    // Tracked level never passes full scale
    `PPM_ASSERT_NOW(a_level_range, bl_valid, 32'(bl_level) <= 32'(LEVEL_MAX))
    // A stalled tick result keeps its level and peak until taken
    `PPM_ASSERT_NEXT(a_bl_hold, bl_valid && !bl_ready, bl_valid && $stable(bl_level) && $stable(bl_peak))

endmodule

`default_nettype wire
